// File: sv/rdq_pkg.sv
// Shared types, constants and control store for the run duration quantizer.
`default_nettype none
package rdq_pkg;

    localparam int DUR_W     = 32;
    localparam int INC_W     = 16;
    localparam int DIV_W     = DUR_W + 1;
    localparam int CNT_W     = $clog2(DIV_W + 1);
    localparam int STEP_W    = 5;
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic [DUR_W-1:0] MIN_RESET = 32'd100;
    localparam logic [DUR_W-1:0] MAX_RESET = 32'd10000000;
    localparam logic [INC_W-1:0] INC_RESET = 16'd100;
    localparam logic [INC_W-1:0] SA_RESET  = 16'd1000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INC = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SA  = 2'd3;

    typedef enum logic [1:0] {
        ST_OK,
        ST_RANGE,
        ST_MULT,
        ST_NOFIT
    } status_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_START,
        C_OUT_RANGE,
        C_INC_ZERO,
        C_DIV_BUSY,
        C_REM_NZ,
        C_SA_ZERO,
        C_P_GT_HI,
        C_REM_ZERO
    } cond_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DIV_DUR,
        OP_LOAD_N,
        OP_DIV_LO,
        OP_LOAD_LO,
        OP_DIV_HI,
        OP_LOAD_HI,
        OP_DIV_P,
        OP_INC_P,
        OP_FOUND,
        OP_EMIT
    } op_t;

    typedef logic [STEP_W-1:0] step_t;

    // Program addresses
    localparam step_t S_IDLE  = 5'd0;
    localparam step_t S_RANGE = 5'd1;
    localparam step_t S_INCZ  = 5'd2;
    localparam step_t S_DDUR  = 5'd3;
    localparam step_t S_WDUR  = 5'd4;
    localparam step_t S_MULT  = 5'd5;
    localparam step_t S_DLO   = 5'd6;
    localparam step_t S_WLO   = 5'd7;
    localparam step_t S_LLO   = 5'd8;
    localparam step_t S_DHI   = 5'd9;
    localparam step_t S_WHI   = 5'd10;
    localparam step_t S_LHI   = 5'd11;
    localparam step_t S_LOOP  = 5'd12;
    localparam step_t S_DP    = 5'd13;
    localparam step_t S_WP    = 5'd14;
    localparam step_t S_TEST  = 5'd15;
    localparam step_t S_NEXT  = 5'd16;
    localparam step_t S_FOUND = 5'd17;
    localparam step_t S_DONE  = 5'd18;

    // One control word: jump to target when cond holds, else fall through
    typedef struct packed {
        cond_t   cond;
        op_t     op;
        logic    set_st;
        status_t st;
        step_t   target;
    } ucode_t;

    // Sequencer to datapath
    typedef struct packed {
        op_t     op;
        logic    status_we;
        status_t status;
        logic    accept;
    } ctl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic out_range;
        logic inc_zero;
        logic sa_zero;
        logic div_busy;
        logic rem_zero;
        logic p_gt_hi;
    } flags_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t word;
        unique case (step)
            S_IDLE:  word = '{C_NOT_START, OP_NONE,    1'b0, ST_OK,    S_IDLE};
            S_RANGE: word = '{C_OUT_RANGE, OP_NONE,    1'b1, ST_RANGE, S_DONE};
            S_INCZ:  word = '{C_INC_ZERO,  OP_NONE,    1'b1, ST_MULT,  S_DONE};
            S_DDUR:  word = '{C_NEVER,     OP_DIV_DUR, 1'b0, ST_OK,    S_IDLE};
            S_WDUR:  word = '{C_DIV_BUSY,  OP_NONE,    1'b0, ST_OK,    S_WDUR};
            S_MULT:  word = '{C_REM_NZ,    OP_LOAD_N,  1'b1, ST_MULT,  S_DONE};
            S_DLO:   word = '{C_SA_ZERO,   OP_DIV_LO,  1'b1, ST_NOFIT, S_DONE};
            S_WLO:   word = '{C_DIV_BUSY,  OP_NONE,    1'b0, ST_OK,    S_WLO};
            S_LLO:   word = '{C_NEVER,     OP_LOAD_LO, 1'b0, ST_OK,    S_IDLE};
            S_DHI:   word = '{C_NEVER,     OP_DIV_HI,  1'b0, ST_OK,    S_IDLE};
            S_WHI:   word = '{C_DIV_BUSY,  OP_NONE,    1'b0, ST_OK,    S_WHI};
            S_LHI:   word = '{C_NEVER,     OP_LOAD_HI, 1'b0, ST_OK,    S_IDLE};
            S_LOOP:  word = '{C_P_GT_HI,   OP_NONE,    1'b1, ST_NOFIT, S_DONE};
            S_DP:    word = '{C_NEVER,     OP_DIV_P,   1'b0, ST_OK,    S_IDLE};
            S_WP:    word = '{C_DIV_BUSY,  OP_NONE,    1'b0, ST_OK,    S_WP};
            S_TEST:  word = '{C_REM_ZERO,  OP_NONE,    1'b0, ST_OK,    S_FOUND};
            S_NEXT:  word = '{C_ALWAYS,    OP_INC_P,   1'b0, ST_OK,    S_LOOP};
            S_FOUND: word = '{C_ALWAYS,    OP_FOUND,   1'b1, ST_OK,    S_DONE};
            S_DONE:  word = '{C_ALWAYS,    OP_EMIT,    1'b0, ST_OK,    S_IDLE};
            default: word = '{C_ALWAYS,    OP_NONE,    1'b0, ST_OK,    S_IDLE};
        endcase
        return word;
    endfunction

endpackage
`default_nettype wire

// File: sv/run_duration_quantizer_core.sv
// done follows accept once a candidate fits or none is left; rejects end before the search.
// Each candidate costs a 33-bit divide of N by the period, a remainder test and a step
// to the next period; the worst case is 65535 candidates.
// One item at a time: busy drops in the cycle of the done strobe, which cannot be stalled.
// Reset (async, active low) restores the default configuration and idles.
`default_nettype none
module run_duration_quantizer_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [rdq_pkg::DUR_W-1:0]     duration_us,
    output logic                               done,
    output logic [1:0]                         status,
    output logic [rdq_pkg::INC_W-1:0]          period_steps,
    output logic [rdq_pkg::INC_W-1:0]          samples_used,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rdq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rdq_pkg::DUR_W-1:0]     cfg_data
);
    import rdq_pkg::*;

    ctl_t   ctl;
    flags_t flags;
    logic   cfg_we;

    // Configuration is written only while idle and no item is offered
    assign cfg_ready = !busy && !start;
    assign cfg_we    = cfg_valid && cfg_ready;

    rdq_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .ctl   (ctl),
        .busy  (busy)
    );

    rdq_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .cfg_valid    (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .duration_us  (duration_us),
        .flags        (flags),
        .done         (done),
        .status       (status),
        .period_steps (period_steps),
        .samples_used (samples_used)
    );

    // A result only follows a running item
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a running item");

    // A successful split has a nonzero period and sample count
    a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_OK) |-> (period_steps != '0 && samples_used != '0))
        else $error("ok result with zero fields");

    // A flagged result carries zero fields
    a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (period_steps == '0 && samples_used == '0))
        else $error("flagged result with nonzero fields");

endmodule
`default_nettype wire

// File: sv/rdq_divider.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
`default_nettype none
module rdq_divider (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [rdq_pkg::DIV_W-1:0]  dividend,
    input  wire logic [rdq_pkg::INC_W-1:0]  divisor,
    output logic                            busy,
    output logic [rdq_pkg::DIV_W-1:0]       quotient,
    output logic [rdq_pkg::INC_W-1:0]       remainder
);
    import rdq_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [INC_W-1:0] rem_reg, rem_next;
    logic [INC_W-1:0] dvs_reg, dvs_next;
    logic [INC_W:0]   trial;
    logic [INC_W:0]   diff;
    logic             ge;

    // Shift in the next dividend bit and try to subtract
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIV_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = trial >= {1'b0, dvs_reg};
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (start)
        begin
            cnt_next = CNT_W'(DIV_W);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[DIV_W-2:0], ge};
            rem_next = ge ? diff[INC_W-1:0] : trial[INC_W-1:0];
        end
    end

    // Hold the bit counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Advance the working registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = cnt_reg != '0;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// File: sv/rdq_sequencer.sv
// Step counter and control store that drive the datapath.
`default_nettype none
module rdq_sequencer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire rdq_pkg::flags_t flags,
    output rdq_pkg::ctl_t        ctl,
    output logic                 busy
);
    import rdq_pkg::*;

    step_t  step_reg, step_next;
    ucode_t word;
    logic   cond_true;

    // Fetch the control word and evaluate its jump condition
    always_comb
    begin
        word = ucode_rom(step_reg);
        unique case (word.cond)
            C_NEVER:     cond_true = 1'b0;
            C_ALWAYS:    cond_true = 1'b1;
            C_NOT_START: cond_true = !start;
            C_OUT_RANGE: cond_true = flags.out_range;
            C_INC_ZERO:  cond_true = flags.inc_zero;
            C_DIV_BUSY:  cond_true = flags.div_busy;
            C_REM_NZ:    cond_true = !flags.rem_zero;
            C_SA_ZERO:   cond_true = flags.sa_zero;
            C_P_GT_HI:   cond_true = flags.p_gt_hi;
            C_REM_ZERO:  cond_true = flags.rem_zero;
            default:     cond_true = 1'b1;
        endcase
    end

    // Jump or fall through
    always_comb
    begin
        step_next = cond_true ? word.target : step_t'(step_reg + 1'b1);
    end

    // Drive the datapath
    always_comb
    begin
        ctl.op        = word.op;
        ctl.status_we = word.set_st && cond_true;
        ctl.status    = word.st;
        ctl.accept    = (step_reg == S_IDLE) && start;
        busy          = step_reg != S_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/rdq_datapath.sv
// Configuration registers, operand registers, divider and result registers.
`default_nettype none
module rdq_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rdq_pkg::ctl_t                 ctl,
    input  wire logic                          cfg_valid,
    input  wire logic [rdq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rdq_pkg::DUR_W-1:0]     cfg_data,
    input  wire logic [rdq_pkg::DUR_W-1:0]     duration_us,
    output rdq_pkg::flags_t                    flags,
    output logic                               done,
    output logic [1:0]                         status,
    output logic [rdq_pkg::INC_W-1:0]          period_steps,
    output logic [rdq_pkg::INC_W-1:0]          samples_used
);
    import rdq_pkg::*;

    logic [DUR_W-1:0] min_reg, max_reg;
    logic [INC_W-1:0] inc_reg, sa_reg;
    logic [DUR_W-1:0] dur_reg, n_reg, p_reg;
    logic [INC_W-1:0] hi_reg, hi_next;
    logic [INC_W-1:0] period_reg, used_reg;
    status_t          status_reg;
    logic             done_reg;

    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [INC_W-1:0] div_divisor;
    logic             div_busy;
    logic [DIV_W-1:0] div_quo;
    logic [INC_W-1:0] div_rem;
    logic [INC_W-1:0] hi_q, hi_n;

    rdq_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Select divider operands for the current step
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = {1'b0, n_reg};
        div_divisor  = inc_reg;
        unique case (ctl.op)
            OP_DIV_DUR:
            begin
                div_start    = 1'b1;
                div_dividend = {1'b0, dur_reg};
                div_divisor  = inc_reg;
            end
            OP_DIV_LO:
            begin
                div_start    = 1'b1;
                div_dividend = {1'b0, n_reg} + {{(DIV_W-INC_W){1'b0}}, sa_reg} - 1'b1;
                div_divisor  = sa_reg;
            end
            OP_DIV_HI:
            begin
                div_start    = 1'b1;
                div_dividend = {1'b0, max_reg};
                div_divisor  = inc_reg;
            end
            OP_DIV_P:
            begin
                div_start    = 1'b1;
                div_dividend = {1'b0, n_reg};
                div_divisor  = p_reg[INC_W-1:0];
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Clamp the upper search bound to the quotient, N and the 16-bit limit
    always_comb
    begin
        hi_q    = (div_quo[DIV_W-1:INC_W] != '0) ? {INC_W{1'b1}} : div_quo[INC_W-1:0];
        hi_n    = (n_reg[DUR_W-1:INC_W] != '0) ? {INC_W{1'b1}} : n_reg[INC_W-1:0];
        hi_next = (hi_q < hi_n) ? hi_q : hi_n;
    end

    // Report conditions to the sequencer
    always_comb
    begin
        flags.out_range = (dur_reg < min_reg) || (dur_reg > max_reg);
        flags.inc_zero  = inc_reg == '0;
        flags.sa_zero   = sa_reg == '0;
        flags.div_busy  = div_busy;
        flags.rem_zero  = div_rem == '0;
        flags.p_gt_hi   = p_reg > {{(DUR_W-INC_W){1'b0}}, hi_reg};
    end

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_RESET;
            max_reg <= MAX_RESET;
            inc_reg <= INC_RESET;
            sa_reg  <= SA_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MIN: min_reg <= cfg_data;
                CFG_MAX: max_reg <= cfg_data;
                CFG_INC: inc_reg <= cfg_data[INC_W-1:0];
                CFG_SA:  sa_reg  <= cfg_data[INC_W-1:0];
                default: ;
            endcase
        end
    end

    // Strobe the result for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            done_reg <= ctl.op == OP_EMIT;
            if (ctl.status_we)
            begin
                status_reg <= ctl.status;
            end
        end
    end

    // Capture the item and update the operand registers
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            dur_reg    <= duration_us;
            period_reg <= '0;
            used_reg   <= '0;
        end
        unique case (ctl.op)
            OP_LOAD_N:  n_reg  <= div_quo[DUR_W-1:0];
            OP_LOAD_LO: p_reg  <= (div_quo == '0) ? DUR_W'(1) : div_quo[DUR_W-1:0];
            OP_LOAD_HI: hi_reg <= hi_next;
            OP_INC_P:   p_reg  <= p_reg + 1'b1;
            OP_FOUND:
            begin
                period_reg <= p_reg[INC_W-1:0];
                used_reg   <= div_quo[INC_W-1:0];
            end
            default: ;
        endcase
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign period_steps = period_reg;
    assign samples_used = used_reg;

endmodule
`default_nettype wire

// File: tb/tb_run_duration_quantizer_core.sv
// Testbench for run_duration_quantizer_core: directed rows, then random items checked by a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_run_duration_quantizer_core;
    import rdq_pkg::*;

    localparam int unsigned NUM_PHASES      = 7;
    localparam int unsigned ITEMS_PER_PHASE = 11;
    localparam int unsigned MAX_TRIES       = 64;
    localparam int unsigned TAIL_CYCLES     = 200;

    typedef struct packed {
        status_t          st;
        logic [INC_W-1:0] period;
        logic [INC_W-1:0] used;
    } quant_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [DUR_W-1:0]     data;
        logic                 known;
        quant_t               want;
    } row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [DUR_W-1:0]     duration_us;
    logic                 done;
    logic [1:0]           status;
    logic [INC_W-1:0]     period_steps;
    logic [INC_W-1:0]     samples_used;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DUR_W-1:0]     cfg_data;

    // Mirror of the configuration registers
    logic [DUR_W-1:0] cur_min_us;
    logic [DUR_W-1:0] cur_max_us;
    logic [INC_W-1:0] cur_inc_us;
    logic [INC_W-1:0] cur_slots;

    quant_t      pending_quant[$];
    row_t        directed_rows[$];
    int unsigned mismatch_count = 0;

    run_duration_quantizer_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .duration_us  (duration_us),
        .done         (done),
        .status       (status),
        .period_steps (period_steps),
        .samples_used (samples_used),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Split a duration into period and sample count; tries counts candidates searched
    function automatic quant_t quantize_duration(input logic [DUR_W-1:0] dur,
                                                 output int unsigned tries);
        quant_t            q;
        longint unsigned   n;
        longint unsigned   lo;
        longint unsigned   hi;
        longint unsigned   p;
        q.st     = ST_NOFIT;
        q.period = '0;
        q.used   = '0;
        tries    = 0;
        if (dur < cur_min_us || dur > cur_max_us)
        begin
            q.st = ST_RANGE;
        end
        else if (cur_inc_us == 0 || dur % cur_inc_us != 0)
        begin
            q.st = ST_MULT;
        end
        else if (cur_slots != 0)
        begin
            n  = dur;
            n  = n / cur_inc_us;
            lo = (n + cur_slots - 1) / cur_slots;
            hi = cur_max_us;
            hi = hi / cur_inc_us;
            if (hi > n)
                hi = n;
            // wider periods are flagged anyway
            if (hi > 65535)
                hi = 65535;
            if (lo == 0)
                lo = 1;
            for (p = lo; p <= hi; p++)
            begin
                tries++;
                if (n % p == 0)
                begin
                    q.st     = ST_OK;
                    q.period = p[INC_W-1:0];
                    q.used   = INC_W'(n / p);
                    break;
                end
            end
        end
        return q;
    endfunction

    // Draw a duration, mostly a valid multiple, keeping the divisor search short
    function automatic logic [DUR_W-1:0] pick_duration();
        logic [DUR_W-1:0] cand;
        logic [DUR_W-1:0] best;
        int unsigned      t;
        int unsigned      best_t;
        int unsigned      mode;
        int unsigned      slot_cap;
        longint unsigned  u;
        longint unsigned  f;
        longint unsigned  d;
        quant_t           q;
        best     = cur_min_us;
        best_t   = 32'hFFFF_FFFF;
        slot_cap = (cur_slots == 0) ? 1 : cur_slots;
        for (int a = 0; a < 40; a++)
        begin
            mode = $urandom_range(0, 9);
            case (mode)
                7: cand = $urandom;
                8:
                begin
                    case ($urandom_range(0, 3))
                        0: cand = cur_min_us;
                        1: cand = cur_max_us;
                        2: cand = cur_min_us - 1;
                        default: cand = cur_max_us + 1;
                    endcase
                end
                default:
                begin
                    u = $urandom_range(1, slot_cap);
                    f = $urandom_range(1, 300);
                    d = u * f;
                    if ($urandom_range(0, 7) == 0)
                        d = $urandom_range(0, 2000);
                    d = d * cur_inc_us;
                    // knock it off the increment grid
                    if (mode == 9 && cur_inc_us > 1)
                        d = d + $urandom_range(1, cur_inc_us - 1);
                    if (d > 64'hFFFF_FFFF)
                        continue;
                    cand = d[DUR_W-1:0];
                end
            endcase
            q = quantize_duration(cand, t);
            if (t <= MAX_TRIES && (mode >= 7 || q.st != ST_RANGE))
                return cand;
            if (t < best_t)
            begin
                best_t = t;
                best   = cand;
            end
        end
        return best;
    endfunction

    function automatic row_t item_row(input logic [DUR_W-1:0] d);
        row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.data = d;
        return r;
    endfunction

    function automatic row_t item_known(input logic [DUR_W-1:0] d, input status_t st,
                                        input logic [INC_W-1:0] per,
                                        input logic [INC_W-1:0] used);
        row_t r;
        r = item_row(d);
        r.known       = 1'b1;
        r.want.st     = st;
        r.want.period = per;
        r.want.used   = used;
        return r;
    endfunction

    function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [DUR_W-1:0] d);
        row_t r;
        r = '0;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.data    = d;
        return r;
    endfunction

    // Drop start and wait until the block is idle with nothing outstanding
    task automatic settle();
        start <= 1'b0;
        while (pending_quant.size() != 0)
            @(posedge clk);
        do @(posedge clk); while (busy);
    endtask

    // Write one register; valid stays high for the caller to drop
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_MIN: cur_min_us = d;
            CFG_MAX: cur_max_us = d;
            CFG_INC: cur_inc_us = d[INC_W-1:0];
            default: cur_slots  = d[INC_W-1:0];
        endcase
    endtask

    // Offer one item and queue its expected result on accept
    task automatic send_item(input logic [DUR_W-1:0] dur, input logic known,
                             input quant_t want);
        quant_t      q;
        int unsigned tries;
        start       <= 1'b1;
        duration_us <= dur;
        do @(posedge clk); while (busy);
        if (known)
            q = want;
        else
            q = quantize_duration(dur, tries);
        pending_quant.push_back(q);
    endtask

    // Compare each result with the oldest pending item
    always @(posedge clk)
    begin : check_results
        quant_t want;
        if (done)
        begin
            if (pending_quant.size() == 0)
            begin
                flag_mismatch("result with no pending item");
            end
            else
            begin
                want = pending_quant.pop_front();
                if (status !== want.st)
                    flag_mismatch($sformatf("status got %0d want %0d", status, want.st));
                if (period_steps !== want.period)
                    flag_mismatch($sformatf("period_steps got %0d want %0d",
                                            period_steps, want.period));
                if (samples_used !== want.used)
                    flag_mismatch($sformatf("samples_used got %0d want %0d",
                                            samples_used, want.used));
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("[run_duration_quantizer_core] ERROR");
        $finish;
    end

    initial
    begin
        row_t             r;
        row_kind_t        prev_kind;
        quant_t           none;
        logic [DUR_W-1:0] min_v;
        logic [DUR_W-1:0] max_v;
        logic [INC_W-1:0] inc_v;
        logic [INC_W-1:0] slots_v;
        logic [INC_W-1:0] junk;
        int unsigned      burst_left;
        int unsigned      gap;

        rst_n       = 1'b0;
        start       = 1'b0;
        duration_us = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        cur_min_us  = MIN_RESET;
        cur_max_us  = MAX_RESET;
        cur_inc_us  = INC_RESET;
        cur_slots   = SA_RESET;
        none        = '0;

        // Reset-time configuration: range edges, plain splits, a prime count
        directed_rows.push_back(item_known(32'd0, ST_RANGE, 16'd0, 16'd0));
        directed_rows.push_back(item_known(32'd99, ST_RANGE, 16'd0, 16'd0));
        directed_rows.push_back(item_known(32'd100, ST_OK, 16'd1, 16'd1));
        directed_rows.push_back(item_known(32'd150, ST_MULT, 16'd0, 16'd0));
        directed_rows.push_back(item_known(32'd10000000, ST_OK, 16'd100, 16'd1000));
        directed_rows.push_back(item_known(32'd10000001, ST_RANGE, 16'd0, 16'd0));
        directed_rows.push_back(item_known(32'hFFFF_FFFF, ST_RANGE, 16'd0, 16'd0));
        directed_rows.push_back(item_row(32'd12300));
        directed_rows.push_back(item_row(32'd100100));
        directed_rows.push_back(item_row(32'd100900));
        // Zero increment, upper data bits dropped; range test still comes first
        directed_rows.push_back(cfg_row(CFG_INC, 32'h0001_0000));
        directed_rows.push_back(item_known(32'd500, ST_MULT, 16'd0, 16'd0));
        directed_rows.push_back(item_known(32'd50, ST_RANGE, 16'd0, 16'd0));
        // Zero sample slots
        directed_rows.push_back(cfg_row(CFG_INC, 32'd100));
        directed_rows.push_back(cfg_row(CFG_SA, 32'd0));
        directed_rows.push_back(item_known(32'd1000, ST_NOFIT, 16'd0, 16'd0));
        // Zero duration accepted
        directed_rows.push_back(cfg_row(CFG_SA, 32'hFFFF_03E8));
        directed_rows.push_back(cfg_row(CFG_MIN, 32'd0));
        directed_rows.push_back(item_known(32'd0, ST_NOFIT, 16'd0, 16'd0));
        // Widest period that fits, then periods that do not
        directed_rows.push_back(cfg_row(CFG_INC, 32'd1));
        directed_rows.push_back(cfg_row(CFG_SA, 32'd1));
        directed_rows.push_back(cfg_row(CFG_MAX, 32'hFFFF_FFFF));
        directed_rows.push_back(item_known(32'd65535, ST_OK, 16'd65535, 16'd1));
        directed_rows.push_back(item_known(32'd65536, ST_NOFIT, 16'd0, 16'd0));
        directed_rows.push_back(item_known(32'hFFFF_FFFF, ST_NOFIT, 16'd0, 16'd0));
        directed_rows.push_back(cfg_row(CFG_MIN, 32'hFFFF_FFFF));
        directed_rows.push_back(item_known(32'hFFFF_FFFE, ST_RANGE, 16'd0, 16'd0));
        directed_rows.push_back(item_known(32'hFFFF_FFFF, ST_NOFIT, 16'd0, 16'd0));
        directed_rows.push_back(cfg_row(CFG_MAX, 32'd0));
        directed_rows.push_back(cfg_row(CFG_MIN, 32'd0));
        directed_rows.push_back(item_known(32'd0, ST_NOFIT, 16'd0, 16'd0));
        directed_rows.push_back(item_known(32'd1, ST_RANGE, 16'd0, 16'd0));
        // Largest increment and slot count
        directed_rows.push_back(cfg_row(CFG_INC, 32'h0000_FFFF));
        directed_rows.push_back(cfg_row(CFG_SA, 32'h0000_FFFF));
        directed_rows.push_back(cfg_row(CFG_MAX, 32'hFFFF_FFFF));
        directed_rows.push_back(item_row(32'hFFFE_0001));
        directed_rows.push_back(item_row(32'd131070));
        directed_rows.push_back(item_known(32'd65536, ST_MULT, 16'd0, 16'd0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed rows
        prev_kind = ROW_ITEM;
        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            if (r.kind == ROW_CFG)
            begin
                if (prev_kind == ROW_ITEM)
                    settle();
                write_reg(r.reg_idx, r.data);
            end
            else
            begin
                if (prev_kind == ROW_CFG)
                    cfg_valid <= 1'b0;
                send_item(r.data, r.known, r.want);
            end
            prev_kind = r.kind;
        end

        // Random phases, each under a fresh configuration
        burst_left = $urandom_range(1, 8);
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case ($urandom_range(0, 3))
                0: min_v = 32'd0;
                3: min_v = $urandom;
                default: min_v = $urandom_range(0, 5000);
            endcase
            case ($urandom_range(0, 3))
                0: max_v = 32'hFFFF_FFFF;
                3: max_v = $urandom;
                default: max_v = $urandom_range(100000, 200000000);
            endcase
            case ($urandom_range(0, 3))
                0: inc_v = 16'd1;
                1: inc_v = 16'hFFFF;
                default: inc_v = $urandom_range(1, 1000);
            endcase
            case ($urandom_range(0, 3))
                0: slots_v = 16'd1;
                1: slots_v = 16'hFFFF;
                default: slots_v = $urandom_range(1, 3000);
            endcase
            settle();
            junk = $urandom;
            write_reg(CFG_MIN, min_v);
            write_reg(CFG_MAX, max_v);
            write_reg(CFG_INC, {junk, inc_v});
            junk = $urandom;
            write_reg(CFG_SA, {junk, slots_v});
            cfg_valid <= 1'b0;

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                send_item(pick_duration(), 1'b0, none);
                if (burst_left > 0)
                    burst_left--;
                if ($urandom_range(0, 24) == 0)
                begin
                    // hold off until every pending item has come back
                    settle();
                end
                else if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 8);
                    case ($urandom_range(0, 2))
                        0: gap = 0;
                        1: gap = $urandom_range(1, 20);
                        default: gap = $urandom_range(20, 400);
                    endcase
                    if (gap != 0)
                    begin
                        start <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
            end
        end

        // Drain, then watch for stray results
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_quant.size() != 0)
            flag_mismatch("items left without a result");
        if (mismatch_count == 0)
            $display("[run_duration_quantizer_core] OK");
        else
            $display("[run_duration_quantizer_core] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
